// ----- hw/rtl/bped_pkg.sv -----
// Shared types and constants for the button press event detector.
package bped_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned LONG_W     = 32;
    localparam int unsigned FLOOR_W    = 16;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_LONG     = 2'd2,
        EV_RELEASED = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_LONG_FLOOR = 2'd2,
        REG_ACTIVE_LOW = 2'd3
    } reg_index_t;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [LONG_W-1:0]     LONG_PRESS_RESET = 32'd1000;
    localparam logic [FLOOR_W-1:0]    LONG_FLOOR_RESET = 16'd0;

endpackage

// ----- hw/rtl/button_press_event_detector.sv -----
// Top level of the debounced button press, long press and release event detector.
//
//  channel  direction  handshake              payload
//  input    in         in_valid / in_stall    now_ms, pin_level
//  output   out        out_valid / out_stall  event_res, held, long_held
//  config   in         APB write / read       debounce, long press, floor, polarity
//
// One transfer per clock while the output register is not stalled; each sample
// is held in the input register and then shows up at the output register.
// The debounce compare, deadline add and flag update happen in the same cycle
// and write the detector state as the sample moves to the output register.
// A stalled output register holds its result and stalls the input side.
// Reset clears the valid bits and detector state and loads the configuration defaults.
module button_press_event_detector
    import bped_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           now_ms,
    input  logic                  pin_level,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            event_res,
    output logic                  held,
    output logic                  long_held,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [LONG_W-1:0]     long_press_reg;
    logic [FLOOR_W-1:0]    long_floor_reg;
    logic                  active_low_reg;

    logic                  in_valid_reg;
    logic [TIME_BITS-1:0]  in_now_reg;
    logic                  in_level_reg;

    logic                  out_valid_reg;
    event_t                event_reg;
    logic                  held_out_reg;
    logic                  long_out_reg;

    logic [TIME_BITS-1:0]  last_reg;
    logic [TIME_BITS-1:0]  last_next;
    logic                  held_reg;
    logic                  held_next;
    logic                  long_held_reg;
    logic                  long_held_next;
    logic [TIME_BITS-1:0]  deadline_reg;
    logic [TIME_BITS-1:0]  deadline_next;
    event_t                event_next;

    logic                  out_free;
    logic                  step;
    logic                  cfg_write;
    reg_index_t            cfg_index;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  sample_due;
    logic                  pressed_level;
    logic                  long_enabled;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            long_floor_reg <= LONG_FLOOR_RESET;
            active_low_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= pwdata[DEBOUNCE_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[LONG_W-1:0];
                REG_LONG_FLOOR: long_floor_reg <= pwdata[FLOOR_W-1:0];
                REG_ACTIVE_LOW: active_low_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_DEBOUNCE:   prdata = DATA_W'(debounce_reg);
            REG_LONG_PRESS: prdata = DATA_W'(long_press_reg);
            REG_LONG_FLOOR: prdata = DATA_W'(long_floor_reg);
            REG_ACTIVE_LOW: prdata = DATA_W'(active_low_reg);
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_now_reg   <= TIME_BITS'(now_ms);
            in_level_reg <= pin_level;
        end
    end

    assign elapsed       = in_now_reg - last_reg;
    assign sample_due    = elapsed > TIME_BITS'(debounce_reg);
    assign pressed_level = !active_low_reg;
    assign long_enabled  = long_press_reg > LONG_W'(long_floor_reg);

    always_comb
    begin
        last_next      = last_reg;
        held_next      = held_reg;
        long_held_next = long_held_reg;
        deadline_next  = deadline_reg;
        event_next     = EV_NONE;
        if (sample_due)
        begin
            last_next = in_now_reg;
            if (in_level_reg == pressed_level)
            begin
                if (!held_reg)
                begin
                    event_next = EV_PRESSED;
                    held_next  = 1'b1;
                    if (long_enabled)
                    begin
                        deadline_next = in_now_reg + TIME_BITS'(long_press_reg);
                    end
                end
                else if (in_now_reg >= deadline_reg && long_enabled && !long_held_reg)
                begin
                    event_next     = EV_LONG;
                    long_held_next = 1'b1;
                end
            end
            else
            begin
                if (held_reg)
                begin
                    event_next = EV_RELEASED;
                end
                held_next      = 1'b0;
                long_held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            held_reg      <= 1'b0;
            long_held_reg <= 1'b0;
            deadline_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                last_reg      <= last_next;
                held_reg      <= held_next;
                long_held_reg <= long_held_next;
                deadline_reg  <= deadline_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg    <= event_next;
            held_out_reg <= held_next;
            long_out_reg <= long_held_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign held      = held_out_reg;
    assign long_held = long_out_reg;

endmodule
